### rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and the volume table of the tone/noise generator.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int NUM_CH    = 4;
    localparam int NUM_TONE  = 3;
    localparam int PERIOD_W  = 10;
    localparam int ATT_W     = 4;
    localparam int VOL_W     = 12;
    localparam int SAMPLE_W  = 14;
    localparam int LFSR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int SEL_W     = 3;
    localparam int RATE_W    = 2;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h8000;
    localparam logic [1:0]        CH_NOISE  = 2'd3;
    localparam logic [RATE_W-1:0] RATE_TONE2 = 2'd3;

    localparam logic       FUNC_WRITE = 1'b0;
    localparam logic       FUNC_TICK  = 1'b1;

    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [ATT_W-1:0]    t_atten;
    typedef logic [VOL_W-1:0]    t_vol;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [NUM_CH-1:0][ATT_W-1:0]      t_atten_arr;
    typedef logic [NUM_TONE-1:0][PERIOD_W-1:0] t_period_arr;

    typedef struct packed {
        logic              wr;
        logic              white;
        logic [RATE_W-1:0] rate;
    } t_noise_ctl;

    localparam logic [VOL_W-1:0] VOL_0  = VOL_W'(0);
    localparam logic [VOL_W-1:0] VOL_1  = VOL_W'(1304 / 14);
    localparam logic [VOL_W-1:0] VOL_2  = VOL_W'(1642 / 14);
    localparam logic [VOL_W-1:0] VOL_3  = VOL_W'(2067 / 14);
    localparam logic [VOL_W-1:0] VOL_4  = VOL_W'(2603 / 14);
    localparam logic [VOL_W-1:0] VOL_5  = VOL_W'(3277 / 14);
    localparam logic [VOL_W-1:0] VOL_6  = VOL_W'(4125 / 14);
    localparam logic [VOL_W-1:0] VOL_7  = VOL_W'(5193 / 14);
    localparam logic [VOL_W-1:0] VOL_8  = VOL_W'(6568 / 14);
    localparam logic [VOL_W-1:0] VOL_9  = VOL_W'(8231 / 14);
    localparam logic [VOL_W-1:0] VOL_10 = VOL_W'(10362 / 14);
    localparam logic [VOL_W-1:0] VOL_11 = VOL_W'(13045 / 14);
    localparam logic [VOL_W-1:0] VOL_12 = VOL_W'(16422 / 14);
    localparam logic [VOL_W-1:0] VOL_13 = VOL_W'(20675 / 14);
    localparam logic [VOL_W-1:0] VOL_14 = VOL_W'(26028 / 14);
    localparam logic [VOL_W-1:0] VOL_15 = VOL_W'(32767 / 14);

    // attenuation 15 is silent, 0 is loudest
    function automatic t_vol vol_lookup(input t_atten att);
        t_vol v;
        unique case (~att)
            4'd0:    v = VOL_0;
            4'd1:    v = VOL_1;
            4'd2:    v = VOL_2;
            4'd3:    v = VOL_3;
            4'd4:    v = VOL_4;
            4'd5:    v = VOL_5;
            4'd6:    v = VOL_6;
            4'd7:    v = VOL_7;
            4'd8:    v = VOL_8;
            4'd9:    v = VOL_9;
            4'd10:   v = VOL_10;
            4'd11:   v = VOL_11;
            4'd12:   v = VOL_12;
            4'd13:   v = VOL_13;
            4'd14:   v = VOL_14;
            default: v = VOL_15;
        endcase
        return v;
    endfunction

endpackage

### rtl/psg_if.sv
// ----------------------------------------------------------------------------
// psg_in_if / psg_out_if
// Valid/ready channels for bus/tick words in and sample words out.
// ----------------------------------------------------------------------------
interface psg_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] write_data;

    modport source (output valid, output func, output write_data, input ready);
    modport sink   (input valid, input func, input write_data, output ready);
endinterface

interface psg_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### rtl/psg_regs.sv
// ----------------------------------------------------------------------------
// psg_regs
// Bus byte decoder: latched selector, attenuation, period and noise control registers.
// ----------------------------------------------------------------------------
module psg_regs
    import psg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [DATA_W-1:0] i_data,
    output t_atten_arr        o_atten_nx,
    output t_period_arr       o_period,
    output t_noise_ctl        o_noise_ctl
);

    logic [SEL_W-1:0]  r_sel,   n_sel;
    t_atten_arr        r_atten, n_atten;
    t_period_arr       r_period, n_period;
    logic [SEL_W-1:0]  r_noise, n_noise;
    logic [1:0]        ch;
    logic              is_low;
    logic              noise_wr;

    always_comb begin
        is_low   = i_data[7];
        n_sel    = is_low ? i_data[6:4] : r_sel;
        ch       = n_sel[2:1];
        n_atten  = r_atten;
        n_period = r_period;
        n_noise  = r_noise;
        noise_wr = 1'b0;
        if (i_wr) begin
            if (n_sel[0]) begin
                n_atten[ch] = i_data[3:0];
            end else if (ch == CH_NOISE) begin
                n_noise  = i_data[2:0];
                noise_wr = 1'b1;
            end else if (is_low) begin
                n_period[ch[1:0]][3:0] = i_data[3:0];
            end else begin
                n_period[ch[1:0]][9:4] = i_data[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel    <= '0;
            r_atten  <= '1;
            r_period <= '0;
            r_noise  <= '0;
        end else if (i_wr) begin
            r_sel    <= n_sel;
            r_atten  <= n_atten;
            r_period <= n_period;
            r_noise  <= n_noise;
        end
    end

    assign o_atten_nx        = n_atten;
    assign o_period          = r_period;
    assign o_noise_ctl.wr    = noise_wr;
    assign o_noise_ctl.white = n_noise[2];
    assign o_noise_ctl.rate  = n_noise[1:0];

endmodule

### rtl/psg_tone.sv
// ----------------------------------------------------------------------------
// psg_tone
// One square-wave tone channel: down counter and output level.
// ----------------------------------------------------------------------------
module psg_tone
    import psg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tick,
    input  t_period i_period,
    output logic    o_level_nx,
    output t_period o_count_nx
);

    t_period r_count, n_count;
    logic    r_level, n_level;
    t_period dec;

    always_comb begin
        dec     = r_count - PERIOD_W'(1);
        n_count = r_count;
        n_level = r_level;
        if (i_tick) begin
            if (r_count == '0) begin
                n_level = 1'b1;
                n_count = i_period;
            end else if (dec == '0) begin
                n_level = ~r_level;
                n_count = i_period;
            end else begin
                n_count = dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_level <= 1'b0;
        end else begin
            r_count <= n_count;
            r_level <= n_level;
        end
    end

    assign o_level_nx = n_level;
    assign o_count_nx = n_count;

endmodule

### rtl/psg_noise.sv
// ----------------------------------------------------------------------------
// psg_noise
// Noise channel: rate counter, half-rate divider and 16-bit LFSR.
// ----------------------------------------------------------------------------
module psg_noise
    import psg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  t_noise_ctl i_ctl,
    input  t_period    i_tone2_nx,
    output logic       o_level_nx
);

    t_period           r_count, n_count;
    logic [LFSR_W-1:0] r_lfsr, n_lfsr;
    logic              r_half, n_half;
    logic              r_level, n_level;
    t_period           dec;
    t_period           reload;
    logic [RATE_W-1:0] code;
    logic              fb;

    always_comb begin
        code   = i_ctl.rate + RATE_W'(1);
        reload = (i_ctl.rate == RATE_TONE2) ? i_tone2_nx : PERIOD_W'({code, 4'b0000});
        dec    = r_count - PERIOD_W'(1);
        fb     = i_ctl.white ? (r_lfsr[3] ^ r_lfsr[0]) : r_lfsr[0];

        n_count = r_count;
        n_lfsr  = r_lfsr;
        n_half  = r_half;
        n_level = r_level;
        if (i_tick) begin
            if (r_count == '0) begin
                n_count = i_tone2_nx;
            end else if (dec == '0) begin
                if (!r_half) begin
                    n_level = r_level ^ r_lfsr[0];
                    n_lfsr  = {fb, r_lfsr[LFSR_W-1:1]};
                end
                n_half  = ~r_half;
                n_count = reload;
            end else begin
                n_count = dec;
            end
        end else if (i_ctl.wr) begin
            n_lfsr  = LFSR_SEED;
            n_count = reload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_lfsr  <= LFSR_SEED;
            r_half  <= 1'b0;
            r_level <= 1'b0;
        end else begin
            r_count <= n_count;
            r_lfsr  <= n_lfsr;
            r_half  <= n_half;
            r_level <= n_level;
        end
    end

    assign o_level_nx = n_level;

endmodule

### rtl/psg_mixer.sv
// ----------------------------------------------------------------------------
// psg_mixer
// Sums table volumes of the high channels into the sample output register.
// ----------------------------------------------------------------------------
module psg_mixer
    import psg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [NUM_CH-1:0]  i_level,
    input  t_atten_arr         i_atten,
    output logic               o_free,
    psg_out_if.source          o_out
);

    logic    r_valid, n_valid;
    t_sample r_sample, n_sample;

    always_comb begin
        n_sample = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (i_level[i]) begin
                n_sample = n_sample + SAMPLE_W'(vol_lookup(i_atten[i]));
            end
        end
    end

    assign o_free  = !r_valid || o_out.ready;
    assign n_valid = i_load || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= n_sample;
        end
    end

    assign o_out.valid  = r_valid;
    assign o_out.sample = r_sample;

endmodule

### rtl/psg_tone_noise_generator.sv
// ----------------------------------------------------------------------------
// psg_tone_noise_generator
// Three tone channels and one noise channel mixed to one 14-bit sample.
//
// i_in carries words of {func, write_data}: func 0 writes a bus byte,
// func 1 advances the generator one tick. For every accepted word one
// sample word leaves on o_out, in order.
// Each accepted word passes the input register, then the state update and
// mix into the sample register, before o_out.valid rises.
// Throughput: one word per cycle while o_out does not stall.
// i_in.ready stays high while the sample register is empty or being taken.
// When o_out stalls, one word waits in the sample register and one more
// in the input register; then i_in.ready drops until o_out.ready returns.
// Reset (synchronous, i_rst_n low): all channels silent (attenuation 15),
// periods and counters zero, levels low, LFSR seeded, no words in flight.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator
    import psg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    psg_in_if.sink    i_in,
    psg_out_if.source o_out
);

    logic              r_in_valid;
    logic              r_func;
    logic [DATA_W-1:0] r_data;
    logic              mix_free;
    logic              adv;
    logic              do_tick;
    logic              do_wr;

    t_atten_arr        atten_nx;
    t_period_arr       period;
    t_noise_ctl        noise_ctl;
    t_period           tone_cnt_nx [NUM_TONE];
    logic [NUM_CH-1:0] level_nx;

    assign adv         = r_in_valid && mix_free;
    assign do_tick     = adv && (r_func == FUNC_TICK);
    assign do_wr       = adv && (r_func == FUNC_WRITE);
    assign i_in.ready  = !r_in_valid || mix_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func <= i_in.func;
            r_data <= i_in.write_data;
        end
    end

    psg_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (do_wr),
        .i_data      (r_data),
        .o_atten_nx  (atten_nx),
        .o_period    (period),
        .o_noise_ctl (noise_ctl)
    );

    for (genvar g = 0; g < NUM_TONE; g++) begin : g_tone
        psg_tone u_tone (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tick     (do_tick),
            .i_period   (period[g]),
            .o_level_nx (level_nx[g]),
            .o_count_nx (tone_cnt_nx[g])
        );
    end

    psg_noise u_noise (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (do_tick),
        .i_ctl      (noise_ctl),
        .i_tone2_nx (tone_cnt_nx[NUM_TONE-1]),
        .o_level_nx (level_nx[NUM_CH-1])
    );

    psg_mixer u_mixer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_level (level_nx),
        .i_atten (atten_nx),
        .o_free  (mix_free),
        .o_out   (o_out)
    );

endmodule
